[hdl/next_prime_search_unit_assert.svh]
// Assertion macros for the next prime search unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef NEXT_PRIME_SEARCH_UNIT_ASSERT_SVH
`define NEXT_PRIME_SEARCH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("next prime search unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next prime search unit assertion failed");

`endif

[hdl/nps_pkg.sv]
// Shared constants, types and control structs for the next prime search unit.
// Used by nps_rem_unit and next_prime_search_unit; depends on nothing.
package nps_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CAND_BITS  = 31;
    localparam int DIV_BITS   = 16;
    localparam int SQ_BITS    = 32;
    localparam int STEP_BITS  = $clog2(CAND_BITS);

    typedef logic [CAND_BITS-1:0] cand_t;
    typedef logic [DIV_BITS-1:0]  divisor_t;
    typedef logic [SQ_BITS-1:0]   square_t;
    typedef logic [STEP_BITS-1:0] step_t;

    typedef struct packed {
        logic     start;
        cand_t    dividend;
        divisor_t divisor;
    } nps_rem_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } nps_rem_stat_t;

endpackage

[hdl/nps_rem_unit.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on nps_pkg for widths and the request and status structs.
module nps_rem_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  nps_pkg::nps_rem_req_t req,
    output nps_pkg::nps_rem_stat_t stat
);

    logic                active_reg;
    logic                active_next;
    logic                done_reg;
    logic                done_next;
    logic                zero_reg;
    logic                zero_next;
    nps_pkg::step_t      count_reg;
    nps_pkg::step_t      count_next;
    nps_pkg::cand_t      dvd_reg;
    nps_pkg::cand_t      dvd_next;
    nps_pkg::divisor_t   rem_reg;
    nps_pkg::divisor_t   rem_next;
    nps_pkg::divisor_t   dsr_reg;
    nps_pkg::divisor_t   dsr_next;
    logic [nps_pkg::DIV_BITS:0] trial;
    logic [nps_pkg::DIV_BITS:0] trial_diff;
    nps_pkg::divisor_t   rem_step;

    always_comb
    begin
        trial      = {rem_reg, dvd_reg[nps_pkg::CAND_BITS-1]};
        trial_diff = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_step = trial_diff[nps_pkg::DIV_BITS-1:0];
        end
        else
        begin
            rem_step = trial[nps_pkg::DIV_BITS-1:0];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        zero_next   = zero_reg;
        count_next  = count_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        if (req.start && !active_reg)
        begin
            active_next = 1'b1;
            count_next  = '0;
            dvd_next    = req.dividend;
            rem_next    = '0;
            dsr_next    = req.divisor;
        end
        else if (active_reg)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[nps_pkg::CAND_BITS-2:0], 1'b0};
            if (count_reg == nps_pkg::step_t'(nps_pkg::CAND_BITS - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
                zero_next   = (rem_step == '0);
            end
            else
            begin
                count_next = nps_pkg::step_t'(count_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign stat.busy     = active_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = zero_reg;

`include "next_prime_search_unit_assert.svh"

    `NPS_ASSERT_SAME(a_rem_less_than_divisor, active_reg && (count_reg != '0), rem_reg < dsr_reg)
    `NPS_ASSERT_NEXT(a_done_ends_run, done_next, !active_reg)
    `NPS_ASSERT_SAME(a_count_in_range, active_reg, count_reg <= nps_pkg::step_t'(nps_pkg::CAND_BITS - 1))

endmodule

[hdl/next_prime_search_unit.sv]
// Top level of the next prime search unit: sequencer, square tracker and output register.
// Depends on nps_pkg, nps_rem_unit and the assertion macro header.
//
// Each beat on the input gives one beat on the output: the smallest prime that is not below
// the signed start value, where start values below two give two. The unit works on one start
// value at a time and holds stall high from acceptance until its result is registered. Each odd
// candidate is tested with the odd divisors d while d*d is at most the candidate; every such
// divisor is a run of the single bit-serial remainder unit, and an even candidate is stepped
// past without a division. The prime 2^31 - 1 alone needs 23169 divisors, and the composites
// tested before a prime add their own divisions to that.
// A finished result sits in an output register, so a new start value is taken while it waits.
module next_prime_search_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] start_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] prime_found
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TEST = 3'd1;
    localparam logic [2:0] ST_LOOP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    nps_pkg::cand_t            cand_reg;
    nps_pkg::cand_t            cand_next;
    nps_pkg::divisor_t         div_reg;
    nps_pkg::divisor_t         div_next;
    nps_pkg::square_t          sq_reg;
    nps_pkg::square_t          sq_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    nps_pkg::cand_t            prime_reg;
    nps_pkg::cand_t            prime_next;
    logic [nps_pkg::VALUE_BITS-1:0] raw_value;
    nps_pkg::cand_t            start_cand;
    logic                      sq_over;
    nps_pkg::nps_rem_req_t     rem_req;
    nps_pkg::nps_rem_stat_t    rem_stat;

    assign raw_value = start_value[nps_pkg::VALUE_BITS-1:0];
    assign sq_over   = sq_reg > nps_pkg::square_t'(cand_reg);

    always_comb
    begin
        if (raw_value[nps_pkg::VALUE_BITS-1]
            || (raw_value[nps_pkg::VALUE_BITS-2:0] < 2))
        begin
            start_cand = nps_pkg::cand_t'(2);
        end
        else
        begin
            start_cand = nps_pkg::cand_t'(raw_value[nps_pkg::VALUE_BITS-2:0]);
        end
    end

    always_comb
    begin
        rem_req.start    = (state_reg == ST_LOOP) && !sq_over;
        rem_req.dividend = cand_reg;
        rem_req.divisor  = div_reg;
    end

    nps_rem_unit u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .stat  (rem_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cand_next  = start_cand;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (cand_reg == nps_pkg::cand_t'(2))
                begin
                    state_next = ST_DONE;
                end
                else if (!cand_reg[0])
                begin
                    cand_next = nps_pkg::cand_t'(cand_reg + 1'b1);
                end
                else
                begin
                    div_next   = nps_pkg::divisor_t'(3);
                    sq_next    = nps_pkg::square_t'(9);
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (sq_over)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.rem_zero)
                    begin
                        cand_next  = nps_pkg::cand_t'(cand_reg + 1'b1);
                        state_next = ST_TEST;
                    end
                    else
                    begin
                        div_next   = nps_pkg::divisor_t'(div_reg + 2'd2);
                        sq_next    = nps_pkg::square_t'(sq_reg + {div_reg, 2'b00} + 3'd4);
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    prime_next     = cand_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign prime_found = prime_reg;

`include "next_prime_search_unit_assert.svh"

    `NPS_ASSERT_SAME(a_start_only_when_free, rem_req.start, !rem_stat.busy)
    `NPS_ASSERT_SAME(a_done_only_in_div, rem_stat.done, state_reg == ST_DIV)
    `NPS_ASSERT_SAME(a_result_odd_or_two, out_valid_reg, prime_reg[0] || (prime_reg == nps_pkg::cand_t'(2)))
    `NPS_ASSERT_NEXT(a_accept_starts_test, in_valid && !in_stall, state_reg == ST_TEST)

endmodule

[verif/tb_top.sv]
// Self-checking testbench for next_prime_search_unit: directed corner starts, then random ones.
// Predicts each prime by trial division and checks every output beat in order.
// Depends on nps_pkg and the next_prime_search_unit RTL.
module tb_top;

    localparam longint CYCLE_LIMIT = 30_000_000;
    localparam int     RANDOM_STARTS = 100;

    class prime_tracker;
        nps_pkg::cand_t expected_primes[$];
        int    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function bit is_prime(longint unsigned n);
            longint unsigned d;
            if (n < 2)
                return 1'b0;
            if (n == 2)
                return 1'b1;
            if (n[0] == 1'b0)
                return 1'b0;
            for (d = 3; d * d <= n; d += 2)
            begin
                if (n % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function nps_pkg::cand_t smallest_prime_from(logic [31:0] raw);
            logic [nps_pkg::VALUE_BITS-1:0] field;
            longint unsigned       n;
            field = raw[nps_pkg::VALUE_BITS-1:0];
            if (field[nps_pkg::VALUE_BITS-1])
                n = 2;
            else
                n = longint'(field);
            if (n < 2)
                n = 2;
            n = n & 64'h7FFF_FFFF;
            while (!is_prime(n))
                n = (n + 1) & 64'h7FFF_FFFF;
            return nps_pkg::cand_t'(n);
        endfunction

        function void note_start(logic [31:0] raw);
            expected_primes.push_back(smallest_prime_from(raw));
        endfunction

        function void check_prime(nps_pkg::cand_t got);
            nps_pkg::cand_t want;
            if (expected_primes.size() == 0)
            begin
                $display("%0t: prime_found expected none, got %0d", $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_primes.pop_front();
                if (got !== want)
                begin
                    $display("%0t: prime_found expected %0d, got %0d", $time, want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_primes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] start_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [30:0] prime_found;

    logic        calm = 1'b0;
    longint      cycle_count = 0;

    prime_tracker tracker = new();

    logic [31:0] corner_starts [18] = '{
        32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd24,
        32'd25, 32'd49, 32'd120, 32'd121, 32'd169, 32'd961, 32'h7FFF_FFFF,
        32'd65521, 32'd65536, 32'd1000000
    };

    next_prime_search_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_value (start_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .prime_found (prime_found)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99, 0) < 28);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_prime(prime_found);
    end

    function automatic logic [31:0] random_start();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 20)
            return {1'b1, 31'($urandom)};
        else if (pick < 25)
            return 32'($urandom_range(3, 0));
        else if (pick < 65)
            return 32'($urandom_range(65535, 2));
        else if (pick < 90)
            return 32'($urandom_range(1 << 20, 65536));
        else if (pick < 97)
            return 32'($urandom_range(1 << 24, 1 << 20));
        else
            return 32'($urandom_range(1 << 26, 1 << 24));
    endfunction

    task automatic send_start(input logic [31:0] value);
        in_valid    <= 1'b1;
        start_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_start(value);
        if (!calm && $urandom_range(99, 0) < 28)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_starts[i])
            send_start(corner_starts[i]);

        for (int i = 0; i < RANDOM_STARTS; i++)
        begin
            if (i == 40)
                calm <= 1'b1;
            if (i == 60)
                calm <= 1'b0;
            send_start(random_start());
        end
        in_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
